[design/bsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg: shared types and codes of the bounded weight stack.
// Holds the request and result payload structs, the command and status codes
// and the status struct of the serial divider.
// ----------------------------------------------------------------------------
package bsa_pkg;

  // Field widths fixed by the interface.
  localparam int CMD_W    = 3;
  localparam int WEIGHT_W = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int AVG_W    = 23;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [AVG_W-1:0]    avg_t;

  // Command codes.
  localparam cmd_t CMD_PUSH = 3'd0;
  localparam cmd_t CMD_POP  = 3'd1;
  localparam cmd_t CMD_PEEK = 3'd2;
  localparam cmd_t CMD_AVG  = 3'd3;
  localparam cmd_t CMD_LIST = 3'd4;

  // Result status codes.
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // One input request.
  typedef struct packed {
    cmd_t    cmd;
    weight_t weight_in;
  } in_req_t;

  // One result.
  typedef struct packed {
    status_t status;
    weight_t weight_out;
    count_t  entry_count;
    avg_t    average_hundredths;
    logic    last;
  } out_res_t;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[design/bsa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_ram: generic single-clock RAM.
// One write port and one read port; read data is registered and holds its
// value on cycles without a read.
// ----------------------------------------------------------------------------
module bsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/bsa_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_div: bit-serial restoring divider.
// Produces one quotient bit per cycle, most significant first, and keeps the
// quotient until the next start.
// ----------------------------------------------------------------------------
module bsa_div #(
  parameter int DW = 28,
  parameter int CW = 5,
  localparam int SCW = $clog2(DW + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DW-1:0]        dividend,
  input  logic [CW-1:0]        divisor,
  output bsa_pkg::div_status_t status,
  output bsa_pkg::avg_t        quotient
);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [SCW-1:0] step_r, step_nxt;
  logic [DW-1:0]  quo_r, quo_nxt;
  logic [CW-1:0]  rem_r, rem_nxt;
  logic [CW-1:0]  dsr_r, dsr_nxt;
  logic [CW:0]    trial;
  logic [CW:0]    diff;
  logic           fits;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = (trial >= {1'b0, dsr_r});

  // Next-state logic: load on start, then shift one bit per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      step_nxt = SCW'(DW);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[DW-2:0], fits};
      rem_nxt  = fits ? diff[CW-1:0] : trial[CW-1:0];
      step_nxt = step_r - SCW'(1);
      if (step_r == SCW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  // The quotient never exceeds the largest weight times one hundred.
  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = bsa_pkg::avg_t'(quo_r);

endmodule

[design/bounded_stack_with_average.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_stack_with_average: bounded stack of 16-bit weights with average.
// Push, pop, peek, average in hundredths and bottom-to-top listing.
// ----------------------------------------------------------------------------
// The weights live in a single-port-read RAM of DEPTH entries; the count and
// the running sum sit in registers. One request is handled at a time, and a
// new one is taken while the previous result still waits in the output
// register. Push and unused codes finish in the execute state, pop and peek
// after one RAM read, average once the bit-serial divider is done with a
// dividend of DW = 23 + clog2(DEPTH + 1) bits, that is 28 at DEPTH 16, which
// it turns into one quotient bit per cycle, and list streams one entry per
// cycle through the RAM read port while the output is not stalled.
// No clearing pass runs after reset; entries are only read below the count.
// ----------------------------------------------------------------------------
module bounded_stack_with_average #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bsa_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bsa_pkg::out_res_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = bsa_pkg::WEIGHT_W + CW;
  localparam int DW = SW + 7;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_READ = 5'b00100,
    S_DIV  = 5'b01000,
    S_LIST = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  bsa_pkg::cmd_t       cmd_r;
  bsa_pkg::weight_t    weight_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [SW-1:0]       sum_r, sum_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  bsa_pkg::out_res_t   out_data_r, out_data_nxt;
  bsa_pkg::out_res_t   res;
  logic                out_load;

  logic                in_accept;
  logic                out_free;
  logic                is_empty;
  logic                is_full;
  logic                list_last;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  bsa_pkg::weight_t    rd_data;

  logic                div_start;
  logic [DW-1:0]       sum_ext;
  logic [DW-1:0]       sum_x100;
  bsa_pkg::div_status_t div_st;
  bsa_pkg::avg_t       div_quot;

  // Entry store.
  bsa_ram #(
    .WIDTH (bsa_pkg::WEIGHT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (weight_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sum times one hundred as 64 + 32 + 4 times the sum.
  assign sum_ext  = DW'(sum_r);
  assign sum_x100 = (sum_ext << 6) + (sum_ext << 5) + (sum_ext << 2);

  // Serial divider for the average.
  bsa_div #(
    .DW (DW),
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_x100),
    .divisor  (count_r),
    .status   (div_st),
    .quotient (div_quot)
  );

  // Handshake terms.
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CW'(DEPTH));
  assign list_last = ((CW'(idx_r) + CW'(1)) == count_r);

  // Command sequencer.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    idx_nxt   = idx_r;
    wr_en     = 1'b0;
    wr_addr   = AW'(count_r);
    rd_en     = 1'b0;
    rd_addr   = AW'(count_r - CW'(1));
    div_start = 1'b0;
    out_load  = 1'b0;
    res       = '0;
    res.status = bsa_pkg::ST_OK;
    res.last   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r)
          bsa_pkg::CMD_PUSH: begin
            if (out_free) begin
              if (is_full) begin
                res.status = bsa_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
                sum_nxt   = sum_r + SW'(weight_r);
              end
              out_load  = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          bsa_pkg::CMD_POP, bsa_pkg::CMD_PEEK: begin
            if (!is_empty) begin
              rd_en     = 1'b1;
              state_nxt = S_READ;
            end else if (out_free) begin
              res.status = bsa_pkg::ST_EMPTY;
              out_load   = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
          bsa_pkg::CMD_AVG: begin
            if (!is_empty) begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end else if (out_free) begin
              res.status = bsa_pkg::ST_EMPTY;
              out_load   = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
          bsa_pkg::CMD_LIST: begin
            if (!is_empty) begin
              idx_nxt   = '0;
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_LIST;
            end else if (out_free) begin
              res.status = bsa_pkg::ST_EMPTY;
              out_load   = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
          default: begin
            // Unused codes leave the state alone and report plain success.
            if (out_free) begin
              out_load  = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_READ: begin
        // Top entry is in the read register; pop also retires it.
        if (out_free) begin
          res.weight_out = rd_data;
          if (cmd_r == bsa_pkg::CMD_POP) begin
            count_nxt = count_r - CW'(1);
            sum_nxt   = sum_r - SW'(rd_data);
          end
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_st.done && out_free) begin
          res.average_hundredths = div_quot;
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LIST: begin
        // Emit the current entry and fetch the next one in the same cycle.
        if (out_free) begin
          res.weight_out = rd_data;
          res.last       = list_last;
          out_load       = 1'b1;
          if (list_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Every result reports the count left after the step.
    res.entry_count = bsa_pkg::count_t'(count_nxt);
  end

  // Output register: freed when taken, loaded with a new result.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request capture, list index and result payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r    <= in_data.cmd;
      weight_r <= in_data.weight_in;
    end
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // The count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  // An empty stack carries no running sum.
  a_sum_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (sum_r == '0))
    else $error("running sum nonzero on empty stack");

  // The list walk stays below the count.
  a_list_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |-> (CW'(idx_r) < count_r))
    else $error("list index beyond stored entries");

  // The divider only runs while an average is pending.
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> (state_r == S_DIV))
    else $error("divider busy outside average");
`endif

endmodule
